>>> design/tcte_pkg.sv
`timescale 1ns / 1ps
// Package for the TCP connection table engine: sizes, command, status,
// state and flag codes, entry and result records. No dependencies.
package tcte_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);

	localparam logic [2:0] CMD_OPEN    = 3'd0;
	localparam logic [2:0] CMD_CONNECT = 3'd1;
	localparam logic [2:0] CMD_SEND    = 3'd2;
	localparam logic [2:0] CMD_CLOSE   = 3'd3;
	localparam logic [2:0] CMD_RECV    = 3'd4;
	localparam logic [2:0] CMD_TICK    = 3'd5;
	localparam logic [2:0] CMD_QUERY   = 3'd6;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_NO_FREE = 2'd1;
	localparam logic [1:0] STS_WRONG   = 2'd2;
	localparam logic [1:0] STS_IGNORED = 2'd3;

	localparam logic [2:0] CS_CLOSED      = 3'd0;
	localparam logic [2:0] CS_SYN_SENT    = 3'd1;
	localparam logic [2:0] CS_ESTABLISHED = 3'd2;
	localparam logic [2:0] CS_FIN_WAIT_1  = 3'd3;
	localparam logic [2:0] CS_CLOSE_WAIT  = 3'd4;
	localparam logic [2:0] CS_LAST_ACK    = 3'd5;

	localparam logic [7:0] FL_FIN = 8'h01;
	localparam logic [7:0] FL_SYN = 8'h02;
	localparam logic [7:0] FL_PSH = 8'h08;
	localparam logic [7:0] FL_ACK = 8'h10;

	localparam logic [1:0] REG_FIRST_PORT = 2'd0;
	localparam logic [1:0] REG_INIT_SEQ   = 2'd1;
	localparam logic [1:0] REG_WINDOW     = 2'd2;
	localparam logic [1:0] REG_TIMEOUT    = 2'd3;

	localparam logic [15:0] RST_FIRST_PORT = 16'd49152;
	localparam logic [31:0] RST_INIT_SEQ   = 32'd1000;
	localparam logic [15:0] RST_WINDOW     = 16'd8192;
	localparam logic [15:0] RST_TIMEOUT    = 16'd500;
	localparam logic [15:0] MIN_SEG_LEN    = 16'd20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_OUT,
		ST_EXEC2
	} seq_state_t;

	typedef struct packed {
		logic        used;
		logic [2:0]  st;
		logic [31:0] raddr;
		logic [15:0] lport;
		logic [15:0] rport;
		logic [31:0] sseq;
		logic [31:0] rack;
		logic [15:0] timer;
	} entry_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [3:0]  idx;
		logic [2:0]  st;
		logic [7:0]  flags;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] daddr;
		logic [15:0] plen;
		logic        last;
	} result_t;

	function automatic result_t mk_status(logic [1:0] sts, logic [IDX_W-1:0] i,
		logic [2:0] st, logic [15:0] sport);
		result_t r;
		r        = '0;
		r.status = sts;
		r.idx    = 4'(i);
		r.st     = st;
		r.sport  = sport;
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic result_t mk_seg(entry_t e, logic [IDX_W-1:0] i,
		logic [7:0] flags, logic [15:0] plen);
		result_t r;
		r       = mk_status(STS_OK, i, e.st, e.lport);
		r.kind  = 1'b1;
		r.flags = flags;
		r.seq   = e.sseq;
		r.ack   = e.rack;
		r.dport = e.rport;
		r.daddr = e.raddr;
		r.plen  = plen;
		return r;
	endfunction

endpackage

>>> design/tcp_connection_table_engine.sv
`timescale 1ns / 1ps
// Top level of the TCP connection table engine: command sequencer over the
// connection table and the shared adder. Depends on tcte_pkg, tcte_table, tcte_alu.
// One transaction is handled at a time and in stall is high until its results are
// taken. Open and receive walk the table one entry per cycle until a free or
// matching entry turns up, tick walks all 16 entries, and every other command
// (and a receive below the minimum segment length) reads its entry directly.
// A FIN on an established connection yields two results; all others yield one.
module tcp_connection_table_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [3:0]  conn_index,
	input  logic [31:0] peer_address,
	input  logic [15:0] peer_port,
	input  logic [15:0] own_port,
	input  logic [31:0] seg_sequence,
	input  logic [7:0]  seg_flags,
	input  logic [15:0] byte_count,
	input  logic [3:0]  header_words,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [1:0]  status,
	output logic [3:0]  entry_index,
	output logic [2:0]  entry_state,
	output logic [7:0]  out_flags,
	output logic [31:0] out_sequence,
	output logic [31:0] out_acknowledge,
	output logic [15:0] out_source_port,
	output logic [15:0] out_dest_port,
	output logic [31:0] out_dest_address,
	output logic [15:0] out_payload_length,
	output logic        last
);
	import tcte_pkg::*;

	seq_state_t state_q, state_nxt;

	logic [15:0] first_port_q, window_q, timeout_q, lport_ctr_q;
	logic [31:0] init_seq_q;

	logic [2:0]       cmd_q;
	logic [IDX_W-1:0] idx_q, ptr_q, scan_q;
	logic [31:0]      addr_q, seq_q;
	logic [15:0]      pport_q, oport_q, bc_q, plen_q;
	logic [7:0]       flags_q;
	logic             found_q, pend2_q;
	result_t          res_q;

	logic             in_acc, out_acc;
	logic [15:0]      hdr_bytes, in_plen;
	logic [IDX_W-1:0] tbl_idx;
	entry_t           ent, ent_nxt;
	logic             tbl_we;
	logic [31:0]      alu_a, alu_b, alu_sum;
	result_t          res_nxt;
	logic             res_load, set_found, clr_found, pend2_nxt, port_adv;
	logic             match;

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	assign hdr_bytes = {10'b0, header_words, 2'b00};
	assign in_plen   = (byte_count > hdr_bytes) ? (byte_count - hdr_bytes) : 16'd0;

	assign tbl_idx = (state_q == ST_SCAN) ? scan_q : ptr_q;
	assign match   = ent.used && (ent.raddr == addr_q) && (ent.rport == pport_q)
		&& (ent.lport == oport_q);

	tcte_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (tbl_idx),
		.we     (tbl_we),
		.wr_ent (ent_nxt),
		.rd_ent (ent)
	);

	tcte_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_port_q <= RST_FIRST_PORT;
			init_seq_q   <= RST_INIT_SEQ;
			window_q     <= RST_WINDOW;
			timeout_q    <= RST_TIMEOUT;
			lport_ctr_q  <= RST_FIRST_PORT;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_PORT: begin
						first_port_q <= cfg_data[15:0];
						lport_ctr_q  <= cfg_data[15:0];
					end
					REG_INIT_SEQ: init_seq_q <= cfg_data;
					REG_WINDOW:   window_q   <= cfg_data[15:0];
					REG_TIMEOUT:  timeout_q  <= cfg_data[15:0];
					default: ;
				endcase
			end else if (port_adv) begin
				lport_ctr_q <= alu_sum[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= 1'b0;
			pend2_q <= 1'b0;
			scan_q  <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			pend2_q <= pend2_nxt;
			if (in_acc) begin
				scan_q <= '0;
				ptr_q  <= conn_index[IDX_W-1:0];
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
				if (set_found) begin
					ptr_q <= scan_q;
				end
			end
			if (set_found) begin
				found_q <= 1'b1;
			end else if (clr_found) begin
				found_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= cmd;
			addr_q  <= peer_address;
			pport_q <= peer_port;
			oport_q <= own_port;
			seq_q   <= seg_sequence;
			flags_q <= seg_flags;
			bc_q    <= byte_count;
			plen_q  <= in_plen;
		end
		if (res_load) begin
			res_q <= res_nxt;
		end
	end

	assign idx_q = ptr_q;

	always_comb begin
		state_nxt = state_q;
		ent_nxt   = ent;
		tbl_we    = 1'b0;
		alu_a     = '0;
		alu_b     = '0;
		res_nxt   = mk_status(STS_IGNORED, '0, CS_CLOSED, 16'd0);
		res_load  = 1'b0;
		set_found = 1'b0;
		clr_found = 1'b0;
		pend2_nxt = pend2_q;
		port_adv  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					clr_found = 1'b1;
					pend2_nxt = 1'b0;
					if (cmd == CMD_OPEN || cmd == CMD_TICK ||
						(cmd == CMD_RECV && byte_count >= MIN_SEG_LEN)) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_EXEC;
					end
				end
			end
			ST_SCAN: begin
				case (cmd_q)
					CMD_OPEN: begin
						if (!ent.used) begin
							set_found = 1'b1;
							state_nxt = ST_EXEC;
						end
					end
					CMD_RECV: begin
						if (match) begin
							set_found = 1'b1;
							state_nxt = ST_EXEC;
						end
					end
					default: begin
						alu_a = {16'b0, ent.timer};
						alu_b = 32'h0000_FFFF;
						if (ent.st == CS_SYN_SENT) begin
							tbl_we = 1'b1;
							if (ent.timer <= 16'd1) begin
								ent_nxt.timer = 16'd0;
								ent_nxt.st    = CS_CLOSED;
							end else begin
								ent_nxt.timer = alu_sum[15:0];
							end
						end
					end
				endcase
				if (scan_q == IDX_W'(NUM_ENTRIES - 1)) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_load  = 1'b1;
				state_nxt = ST_OUT;
				case (cmd_q)
					CMD_OPEN: begin
						if (found_q) begin
							alu_a         = {16'b0, lport_ctr_q};
							alu_b         = 32'd1;
							port_adv      = 1'b1;
							tbl_we        = 1'b1;
							ent_nxt.used  = 1'b1;
							ent_nxt.st    = CS_CLOSED;
							ent_nxt.lport = lport_ctr_q;
							ent_nxt.sseq  = init_seq_q;
							res_nxt = mk_status(STS_OK, idx_q, CS_CLOSED, lport_ctr_q);
						end else begin
							res_nxt = mk_status(STS_NO_FREE, '0, CS_CLOSED, 16'd0);
						end
					end
					CMD_CONNECT: begin
						if (!ent.used || ent.st != CS_CLOSED) begin
							res_nxt = mk_status(STS_WRONG, idx_q, ent.st, 16'd0);
						end else begin
							tbl_we        = 1'b1;
							ent_nxt.raddr = addr_q;
							ent_nxt.rport = pport_q;
							ent_nxt.st    = CS_SYN_SENT;
							ent_nxt.timer = timeout_q;
							res_nxt       = mk_seg(ent_nxt, idx_q, FL_SYN, 16'd0);
							alu_a         = ent.sseq;
							alu_b         = 32'd1;
							ent_nxt.sseq  = alu_sum;
						end
					end
					CMD_SEND: begin
						if (!ent.used || ent.st != CS_ESTABLISHED) begin
							res_nxt = mk_status(STS_WRONG, idx_q, ent.st, 16'd0);
						end else begin
							tbl_we       = 1'b1;
							res_nxt      = mk_seg(ent, idx_q, FL_PSH | FL_ACK, bc_q);
							alu_a        = ent.sseq;
							alu_b        = {16'b0, bc_q};
							ent_nxt.sseq = alu_sum;
						end
					end
					CMD_CLOSE: begin
						tbl_we        = 1'b1;
						ent_nxt.used  = 1'b0;
						ent_nxt.st    = CS_CLOSED;
						ent_nxt.timer = 16'd0;
						if (ent.st == CS_ESTABLISHED) begin
							res_nxt      = mk_seg(ent_nxt, idx_q, FL_FIN | FL_ACK, 16'd0);
							alu_a        = ent.sseq;
							alu_b        = 32'd1;
							ent_nxt.sseq = alu_sum;
						end else begin
							res_nxt = mk_status(STS_OK, idx_q, CS_CLOSED, 16'd0);
						end
					end
					CMD_RECV: begin
						alu_a = seq_q;
						alu_b = 32'd1;
						if (!found_q) begin
							res_nxt = mk_status(STS_IGNORED, '0, CS_CLOSED, 16'd0);
						end else if (ent.st == CS_SYN_SENT && (flags_q & FL_SYN) != 8'd0
							&& (flags_q & FL_ACK) != 8'd0) begin
							tbl_we        = 1'b1;
							ent_nxt.rack  = alu_sum;
							ent_nxt.st    = CS_ESTABLISHED;
							ent_nxt.timer = 16'd0;
							res_nxt       = mk_seg(ent_nxt, idx_q, FL_ACK, 16'd0);
						end else if (ent.st == CS_ESTABLISHED
							&& (flags_q & FL_FIN) != 8'd0) begin
							tbl_we       = 1'b1;
							ent_nxt.rack = alu_sum;
							ent_nxt.st   = CS_CLOSE_WAIT;
							res_nxt      = mk_seg(ent_nxt, idx_q, FL_ACK, 16'd0);
							res_nxt.last = 1'b0;
							pend2_nxt    = 1'b1;
						end else if (ent.st == CS_ESTABLISHED && (flags_q & FL_ACK) != 8'd0
							&& plen_q != 16'd0) begin
							alu_b        = {16'b0, plen_q};
							tbl_we       = 1'b1;
							ent_nxt.rack = alu_sum;
							res_nxt      = mk_seg(ent_nxt, idx_q, FL_ACK, 16'd0);
						end else if (ent.st == CS_LAST_ACK && (flags_q & FL_ACK) != 8'd0) begin
							tbl_we     = 1'b1;
							ent_nxt.st = CS_CLOSED;
							res_nxt    = mk_status(STS_OK, idx_q, CS_CLOSED, 16'd0);
						end else begin
							res_nxt = mk_status(STS_IGNORED, idx_q, ent.st, 16'd0);
						end
					end
					CMD_TICK: begin
						res_nxt = mk_status(STS_OK, '0, CS_CLOSED, 16'd0);
					end
					CMD_QUERY: begin
						res_nxt = mk_status(STS_OK, idx_q, ent.st, 16'd0);
					end
					default: begin
						res_nxt = mk_status(STS_IGNORED, '0, CS_CLOSED, 16'd0);
					end
				endcase
			end
			ST_EXEC2: begin
				res_load     = 1'b1;
				pend2_nxt    = 1'b0;
				state_nxt    = ST_OUT;
				tbl_we       = 1'b1;
				ent_nxt.st   = CS_LAST_ACK;
				res_nxt      = mk_seg(ent_nxt, idx_q, FL_FIN | FL_ACK, 16'd0);
				alu_a        = ent.sseq;
				alu_b        = 32'd1;
				ent_nxt.sseq = alu_sum;
			end
			ST_OUT: begin
				if (out_acc) begin
					state_nxt = pend2_q ? ST_EXEC2 : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign result_kind        = res_q.kind;
	assign status             = res_q.status;
	assign entry_index        = res_q.idx;
	assign entry_state        = res_q.st;
	assign out_flags          = res_q.flags;
	assign out_sequence       = res_q.seq;
	assign out_acknowledge    = res_q.ack;
	assign out_source_port    = res_q.sport;
	assign out_dest_port      = res_q.dport;
	assign out_dest_address   = res_q.daddr;
	assign out_payload_length = res_q.plen;
	assign last               = res_q.last;

	logic [15:0] unused_cfg;
	assign unused_cfg = first_port_q ^ window_q;

	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (result_kind && entry_state == CS_CLOSE_WAIT))
		else $error("non-final result is not the close-wait ACK");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (state_q == ST_EXEC2))
		else $error("second result not issued after the first");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (scan_q == '0))
		else $error("table walk does not start at entry zero");
endmodule

>>> design/tcte_alu.sv
`timescale 1ns / 1ps
// Shared 32-bit adder for sequence, acknowledge, timer and port updates.
// Depends on nothing.
module tcte_alu (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum
);
	assign sum = a + b;
endmodule

>>> design/tcte_table.sv
`timescale 1ns / 1ps
// Connection table: one entry record per connection, one read and one write
// port at the same address. Depends on tcte_pkg.
module tcte_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tcte_pkg::IDX_W-1:0] idx,
	input  logic                      we,
	input  tcte_pkg::entry_t          wr_ent,
	output tcte_pkg::entry_t          rd_ent
);
	import tcte_pkg::*;

	entry_t tbl_q [NUM_ENTRIES];

	assign rd_ent = tbl_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				tbl_q[i] <= '0;
			end
		end else if (we) begin
			tbl_q[idx] <= wr_ent;
		end
	end
endmodule

>>> sim/tb_tcp_connection_table_engine.sv
`timescale 1ns / 1ps
// Testbench for tcp_connection_table_engine: directed and random command streams
// checked against a behavioral copy of the connection table. Depends on tcte_pkg and tcp_connection_table_engine.
module tb_tcp_connection_table_engine;
	import tcte_pkg::*;

	class conn_table_scoreboard;
		logic        used[16];
		logic [2:0]  cst[16];
		logic [31:0] raddr[16];
		logic [15:0] lport[16];
		logic [15:0] rport[16];
		logic [31:0] sseq[16];
		logic [31:0] rack[16];
		logic [15:0] timer[16];
		logic [15:0] lport_ctr;
		logic [15:0] cfg_port;
		logic [31:0] cfg_seq;
		logic [15:0] cfg_window;
		logic [15:0] cfg_timeout;
		result_t     pending[$];
		int          errors;
		int          seen;

		function new();
			errors = 0;
			seen = 0;
			cfg_port = RST_FIRST_PORT;
			cfg_seq = RST_INIT_SEQ;
			cfg_window = RST_WINDOW;
			cfg_timeout = RST_TIMEOUT;
			lport_ctr = RST_FIRST_PORT;
			for (int i = 0; i < 16; i++) begin
				used[i] = 0; cst[i] = CS_CLOSED; raddr[i] = 0; lport[i] = 0;
				rport[i] = 0; sseq[i] = 0; rack[i] = 0; timer[i] = 0;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_FIRST_PORT: begin
					cfg_port = v[15:0];
					lport_ctr = v[15:0];
				end
				REG_INIT_SEQ: cfg_seq = v;
				REG_WINDOW:   cfg_window = v[15:0];
				REG_TIMEOUT:  cfg_timeout = v[15:0];
			endcase
		endfunction

		function result_t status_res(logic [1:0] s, int i, logic [2:0] st,
			logic [15:0] sp);
			result_t r;
			r = '0;
			r.status = s;
			r.idx = i[3:0];
			r.st = st;
			r.sport = sp;
			return r;
		endfunction

		function result_t seg_res(int i, logic [7:0] fl, logic [15:0] pl);
			result_t r;
			r = status_res(STS_OK, i, cst[i], lport[i]);
			r.kind = 1;
			r.flags = fl;
			r.seq = sseq[i];
			r.ack = rack[i];
			r.dport = rport[i];
			r.daddr = raddr[i];
			r.plen = pl;
			return r;
		endfunction

		function void receive(logic [31:0] a, logic [15:0] pp, logic [15:0] op,
			logic [31:0] sq, logic [7:0] fl, logic [15:0] tot, logic [3:0] hw,
			output result_t r0, output result_t r1, output int n);
			int m;
			logic [15:0] hdr, pl;
			n = 1;
			m = -1;
			r0 = status_res(STS_IGNORED, 0, CS_CLOSED, 0);
			if (tot < MIN_SEG_LEN) return;
			for (int i = 0; i < 16; i++)
				if (m < 0 && used[i] && raddr[i] == a && rport[i] == pp && lport[i] == op)
					m = i;
			if (m < 0) return;
			r0 = status_res(STS_IGNORED, m, cst[m], 0);
			if (cst[m] == CS_SYN_SENT) begin
				if ((fl & FL_SYN) != 0 && (fl & FL_ACK) != 0) begin
					rack[m] = sq + 32'd1;
					cst[m] = CS_ESTABLISHED;
					timer[m] = 0;
					r0 = seg_res(m, FL_ACK, 0);
				end
			end else if (cst[m] == CS_ESTABLISHED) begin
				if ((fl & FL_FIN) != 0) begin
					rack[m] = sq + 32'd1;
					cst[m] = CS_CLOSE_WAIT;
					r0 = seg_res(m, FL_ACK, 0);
					cst[m] = CS_LAST_ACK;
					r1 = seg_res(m, FL_FIN | FL_ACK, 0);
					sseq[m] = sseq[m] + 32'd1;
					n = 2;
				end else if ((fl & FL_ACK) != 0) begin
					hdr = {10'd0, hw, 2'd0};
					pl = tot > hdr ? tot - hdr : 16'd0;
					if (pl != 0) begin
						rack[m] = sq + {16'd0, pl};
						r0 = seg_res(m, FL_ACK, 0);
					end
				end
			end else if (cst[m] == CS_LAST_ACK) begin
				if ((fl & FL_ACK) != 0) begin
					cst[m] = CS_CLOSED;
					r0 = status_res(STS_OK, m, CS_CLOSED, 0);
				end
			end
		endfunction

		// predict results of one accepted command
		function void note_command(logic [2:0] c, logic [3:0] ix, logic [31:0] a,
			logic [15:0] pp, logic [15:0] op, logic [31:0] sq, logic [7:0] fl,
			logic [15:0] bc, logic [3:0] hw);
			result_t r0, r1;
			int n;
			n = 1;
			r0 = status_res(STS_IGNORED, 0, CS_CLOSED, 0);
			case (c)
				CMD_OPEN: begin
					r0 = status_res(STS_NO_FREE, 0, CS_CLOSED, 0);
					for (int i = 0; i < 16; i++)
						if (!used[i]) begin
							used[i] = 1;
							cst[i] = CS_CLOSED;
							lport[i] = lport_ctr;
							lport_ctr = lport_ctr + 16'd1;
							sseq[i] = cfg_seq;
							r0 = status_res(STS_OK, i, CS_CLOSED, lport[i]);
							break;
						end
				end
				CMD_CONNECT: begin
					if (!used[ix] || cst[ix] != CS_CLOSED)
						r0 = status_res(STS_WRONG, ix, cst[ix], 0);
					else begin
						raddr[ix] = a;
						rport[ix] = pp;
						cst[ix] = CS_SYN_SENT;
						timer[ix] = cfg_timeout;
						r0 = seg_res(ix, FL_SYN, 0);
						sseq[ix] = sseq[ix] + 32'd1;
					end
				end
				CMD_SEND: begin
					if (!used[ix] || cst[ix] != CS_ESTABLISHED)
						r0 = status_res(STS_WRONG, ix, cst[ix], 0);
					else begin
						r0 = seg_res(ix, FL_PSH | FL_ACK, bc);
						sseq[ix] = sseq[ix] + {16'd0, bc};
					end
				end
				CMD_CLOSE: begin
					if (cst[ix] == CS_ESTABLISHED) begin
						cst[ix] = CS_CLOSED;
						r0 = seg_res(ix, FL_FIN | FL_ACK, 0);
						sseq[ix] = sseq[ix] + 32'd1;
					end else
						r0 = status_res(STS_OK, ix, CS_CLOSED, 0);
					used[ix] = 0;
					cst[ix] = CS_CLOSED;
					timer[ix] = 0;
				end
				CMD_RECV: receive(a, pp, op, sq, fl, bc, hw, r0, r1, n);
				CMD_TICK: begin
					for (int i = 0; i < 16; i++)
						if (cst[i] == CS_SYN_SENT) begin
							if (timer[i] <= 1) begin
								timer[i] = 0;
								cst[i] = CS_CLOSED;
							end else
								timer[i] = timer[i] - 16'd1;
						end
					r0 = status_res(STS_OK, 0, CS_CLOSED, 0);
				end
				CMD_QUERY: r0 = status_res(STS_OK, ix, cst[ix], 0);
				default: ;
			endcase
			if (n == 2) begin
				r1.last = 1;
				pending.push_back(r0);
				pending.push_back(r1);
			end else begin
				r0.last = 1;
				pending.push_back(r0);
			end
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 40)
				$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		endfunction

		function void check_result(result_t g);
			result_t w;
			seen++;
			if (pending.size() == 0) begin
				report("unexpected result", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (g.kind != w.kind) report("result_kind", g.kind, w.kind);
			if (g.status != w.status) report("status", g.status, w.status);
			if (g.idx != w.idx) report("entry_index", g.idx, w.idx);
			if (g.st != w.st) report("entry_state", g.st, w.st);
			if (g.flags != w.flags) report("out_flags", g.flags, w.flags);
			if (g.seq != w.seq) report("out_sequence", g.seq, w.seq);
			if (g.ack != w.ack) report("out_acknowledge", g.ack, w.ack);
			if (g.sport != w.sport) report("out_source_port", g.sport, w.sport);
			if (g.dport != w.dport) report("out_dest_port", g.dport, w.dport);
			if (g.daddr != w.daddr) report("out_dest_address", g.daddr, w.daddr);
			if (g.plen != w.plen) report("out_payload_length", g.plen, w.plen);
			if (g.last != w.last) report("last", g.last, w.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [3:0]  conn_index;
	logic [31:0] peer_address;
	logic [15:0] peer_port;
	logic [15:0] own_port;
	logic [31:0] seg_sequence;
	logic [7:0]  seg_flags;
	logic [15:0] byte_count;
	logic [3:0]  header_words;
	logic        out_valid;
	logic        out_stall;
	logic        result_kind;
	logic [1:0]  status;
	logic [3:0]  entry_index;
	logic [2:0]  entry_state;
	logic [7:0]  out_flags;
	logic [31:0] out_sequence;
	logic [31:0] out_acknowledge;
	logic [15:0] out_source_port;
	logic [15:0] out_dest_port;
	logic [31:0] out_dest_address;
	logic [15:0] out_payload_length;
	logic        last;

	conn_table_scoreboard conn_sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;

	tcp_connection_table_engine i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("Simulation FAILED");
		$finish;
	end

	// sample results and drive output stall
	always @(posedge clk) begin
		result_t g;
		if (arst_n && out_valid && !out_stall) begin
			g.kind = result_kind; g.status = status; g.idx = entry_index;
			g.st = entry_state; g.flags = out_flags; g.seq = out_sequence;
			g.ack = out_acknowledge; g.sport = out_source_port;
			g.dport = out_dest_port; g.daddr = out_dest_address;
			g.plen = out_payload_length; g.last = last;
			conn_sb.check_result(g);
		end
	end

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		conn_sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// present one transaction and hold it until accepted
	task automatic issue(logic [2:0] c, logic [3:0] ix, logic [31:0] a,
		logic [15:0] pp, logic [15:0] op, logic [31:0] sq, logic [7:0] fl,
		logic [15:0] bc, logic [3:0] hw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		cmd <= c; conn_index <= ix; peer_address <= a; peer_port <= pp;
		own_port <= op; seg_sequence <= sq; seg_flags <= fl; byte_count <= bc;
		header_words <= hw;
		do @(posedge clk); while (in_stall);
		conn_sb.note_command(c, ix, a, pp, op, sq, fl, bc, hw);
		@(negedge clk);
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 0;
		while (conn_sb.pending.size() != 0 && n < 100000) begin
			@(negedge clk);
			n++;
		end
		repeat (30) @(negedge clk);
	endtask

	logic [31:0] peer_pool[4] = '{32'h0a000001, 32'hc0a80102, 32'hffffffff, 32'h0};
	logic [15:0] pport_pool[4] = '{16'd80, 16'd443, 16'hffff, 16'd0};

	task automatic random_items(int count);
		logic [2:0]  c;
		logic [3:0]  ix;
		logic [31:0] a;
		logic [15:0] pp, op, bc;
		logic [7:0]  fl;
		int k;
		for (int n = 0; n < count; n++) begin
			c = 3'($urandom_range(6));
			if ($urandom_range(49) == 0) c = 3'd7;
			ix = 4'($urandom_range(15));
			a = peer_pool[$urandom_range(3)];
			pp = pport_pool[$urandom_range(3)];
			op = conn_sb.lport[ix];
			fl = 8'($urandom);
			bc = 16'($urandom_range(19, 300));
			k = $urandom_range(9);
			if (c == CMD_RECV && k < 7 && conn_sb.used[ix]) begin
				// well-formed segment for a live connection
				a = conn_sb.raddr[ix];
				pp = conn_sb.rport[ix];
				if (conn_sb.cst[ix] == CS_SYN_SENT) fl = FL_SYN | FL_ACK;
				else if (conn_sb.cst[ix] == CS_ESTABLISHED)
					fl = k < 2 ? (FL_FIN | FL_ACK) : (FL_ACK | FL_PSH);
				else fl = FL_ACK;
			end else if (k == 9) begin
				a = $urandom;
				pp = 16'($urandom);
				op = 16'($urandom);
				bc = 16'($urandom);
			end
			if (c == CMD_CLOSE && $urandom_range(3) != 0) c = CMD_SEND;
			issue(c, ix, a, pp, op, $urandom, fl, bc, 4'($urandom));
		end
	endtask

	initial begin
		conn_sb = new();
		arst_n = 0;
		cfg_we = 0; cfg_index = REG_FIRST_PORT; cfg_data = 0;
		in_valid = 0; cmd = CMD_QUERY; conn_index = 0; peer_address = 0;
		peer_port = 0; own_port = 0; seg_sequence = 0; seg_flags = 0;
		byte_count = 0; header_words = 0; out_stall = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);

		// directed: open all, overflow, full connection life
		for (int i = 0; i < 17; i++)
			issue(CMD_OPEN, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_CONNECT, 0, 32'hffffffff, 16'hffff, 0, 0, 0, 0, 0);
		issue(CMD_CONNECT, 0, 32'h1, 16'h1, 0, 0, 0, 0, 0);
		issue(CMD_RECV, 0, 32'hffffffff, 16'hffff, conn_sb.lport[0], 32'hffffffff,
			FL_SYN | FL_ACK, 16'd20, 4'd5);
		issue(CMD_SEND, 0, 0, 0, 0, 0, 0, 16'hffff, 0);
		issue(CMD_RECV, 0, 32'hffffffff, 16'hffff, conn_sb.lport[0], 32'h5,
			FL_ACK, 16'hffff, 4'hf);
		issue(CMD_RECV, 0, 32'hffffffff, 16'hffff, conn_sb.lport[0], 32'h5,
			FL_ACK, 16'd20, 4'hf);
		issue(CMD_RECV, 0, 32'hffffffff, 16'hffff, conn_sb.lport[0], 32'h5,
			FL_ACK, 16'd19, 4'h0);
		issue(CMD_RECV, 0, 32'hffffffff, 16'hffff, conn_sb.lport[0], 32'h9,
			8'hff, 16'd40, 4'h5);
		issue(CMD_RECV, 0, 32'hffffffff, 16'hffff, conn_sb.lport[0], 0,
			FL_ACK, 16'd20, 4'h5);
		issue(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(CMD_CLOSE, 4'hf, 0, 0, 0, 0, 0, 0, 0);
		drain();

		// sweep register settings, including extremes, and input/output pacing, under random commands
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 60; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 60; end
				3: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			write_reg(REG_FIRST_PORT, ph == 1 ? 32'hfffe : ph == 2 ? 32'h0 : $urandom);
			write_reg(REG_INIT_SEQ, ph == 1 ? 32'hffffffff : ph == 2 ? 32'h0 : $urandom);
			write_reg(REG_WINDOW, ph == 1 ? 32'hffff : ph == 2 ? 32'h0 : $urandom);
			write_reg(REG_TIMEOUT, ph == 1 ? 32'hffff : ph == 2 ? 32'h1 :
				32'($urandom_range(1, 8)));
			for (int i = 0; i < 16; i++)
				issue(CMD_CLOSE, 4'(i), 0, 0, 0, 0, 0, 0, 0);
			if (ph == 3) hold_off_cycles = 400;
			random_items(300);
			drain();
		end

		if (conn_sb.errors == 0 && conn_sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

>>> files.f
design/tcte_pkg.sv
design/tcte_alu.sv
design/tcte_table.sv
design/tcp_connection_table_engine.sv
sim/tb_tcp_connection_table_engine.sv
